/* rtl/optt_pkg.sv */
// ----------------------------------------------------------------------------
// optt_pkg: shared types and constants for the timer slot table
// Operation and status codes, the controller state type and fixed field widths.
// ----------------------------------------------------------------------------
package optt_pkg;

  // Default sizes of the table and of the time counter.
  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  // Fixed widths of the item fields.
  localparam int DELAY_W  = 31;
  localparam int SLOT_F_W = 4;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_START_ONESHOT  = 2'd0,
    OP_START_PERIODIC = 2'd1,
    OP_CANCEL         = 2'd2,
    OP_TICK           = 2'd3
  } op_t;

  // Status codes carried by a result item.
  typedef enum logic [2:0] {
    STS_STARTED   = 3'd0,
    STS_FULL      = 3'd1,
    STS_CANCELLED = 3'd2,
    STS_EXPIRED   = 3'd3,
    STS_IDLE_TICK = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FLUSH
  } state_t;

endpackage

/* rtl/optt_ram.sv */
// ----------------------------------------------------------------------------
// optt_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module optt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/oneshot_periodic_timer_table.sv */
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_table: one-shot and periodic timer slot table
// Start, cancel and tick operations over a table of timer slots.
// ----------------------------------------------------------------------------
// Usage:
//   An item is accepted at a clock edge where start is high and busy is low.
//   in_operation selects start one-shot, start periodic, cancel or tick.
//   Each result is shown for one cycle with out_valid high; out_last marks
//   the final result of an item. The receiver cannot stall the block.
// Sequencing:
//   On start or cancel, busy is high for one cycle and the result is shown
//   in the next cycle, in which a new item can already be accepted.
//   A tick walks the slot memory one entry per cycle (one read port, one
//   write-back port) in S_SCAN, then moves to S_FLUSH; busy stays high
//   through both states, and a new item can already be accepted while the
//   final result is shown. An expired slot is held until the next expired
//   slot is found or the walk ends, so that out_last can be set on the
//   final one.
// Reset:
//   Synchronous reset clears the time counter and every slot's in-use bit.
//   The slot memory needs no clearing: an entry is read only while in use.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_table #(
  parameter int SLOTS     = optt_pkg::SLOTS_DEF,
  parameter int TIME_BITS = optt_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_operation,
  input  logic [optt_pkg::DELAY_W-1:0] in_delay_ticks,
  input  logic [3:0]                  in_slot_index,
  output logic                        out_valid,
  output logic [3:0]                  out_slot,
  output logic [2:0]                  out_status,
  output logic                        out_last
);

  localparam int SW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int DW  = optt_pkg::DELAY_W;
  localparam int EW  = TIME_BITS + 1 + DW;
  localparam int OSW = optt_pkg::SLOT_F_W;

  optt_pkg::state_t state_r, state_nxt;

  logic [TIME_BITS-1:0] time_r;
  logic [SLOTS-1:0]     in_use_r;

  // Captured command.
  optt_pkg::op_t  cmd_op_r;
  logic [DW-1:0]  cmd_delay_r;
  logic [3:0]     cmd_idx_r;

  // Scan pipeline: read issue counter, evaluation stage and held result.
  logic [CW-1:0]  cnt_r;
  logic           eval_vld_r;
  logic [SW-1:0]  eval_idx_r;
  logic           pend_vld_r;
  logic [SW-1:0]  pend_idx_r;

  // Output registers.
  logic           out_valid_r, out_valid_nxt;
  logic [OSW-1:0] out_slot_r, out_slot_nxt;
  optt_pkg::status_t out_status_r, out_status_nxt;
  logic           out_last_r, out_last_nxt;

  logic           accept;
  logic           scan_done;
  logic           free_found;
  logic [SW-1:0]  free_idx;
  logic           cancel_hit;

  logic           ram_we;
  logic [SW-1:0]  ram_waddr;
  logic [EW-1:0]  ram_wdata;
  logic [EW-1:0]  ram_rdata;

  logic [TIME_BITS-1:0] rd_expiry;
  logic                 rd_repeats;
  logic [DW-1:0]        rd_period;
  logic [TIME_BITS-1:0] diff;
  logic                 expired;

  // Slot memory: {expiry, repeats, period} per slot.
  optt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[SW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_period  = ram_rdata[DW-1:0];
  assign rd_repeats = ram_rdata[DW];
  assign rd_expiry  = ram_rdata[EW-1:DW+1];

  // Expiry test by wrap-around signed difference against the new time.
  assign diff    = rd_expiry - time_r;
  assign expired = eval_vld_r && in_use_r[eval_idx_r] &&
                   ((diff == '0) || diff[TIME_BITS-1]);

  assign scan_done  = (cnt_r == CW'(SLOTS));
  assign cancel_hit = (int'(cmd_idx_r) < SLOTS);

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Memory write: arming on start, re-arming of a periodic slot during a scan.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = eval_idx_r;
    ram_wdata = {time_r + TIME_BITS'(rd_period), 1'b1, rd_period};
    if (state_r == optt_pkg::S_EXEC) begin
      ram_we    = (cmd_op_r != optt_pkg::OP_CANCEL) && free_found;
      ram_waddr = free_idx;
      ram_wdata = {time_r + TIME_BITS'(cmd_delay_r),
                   cmd_op_r == optt_pkg::OP_START_PERIODIC, cmd_delay_r};
    end else if (state_r == optt_pkg::S_SCAN) begin
      ram_we    = expired && rd_repeats;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      optt_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (optt_pkg::op_t'(in_operation) == optt_pkg::OP_TICK) ?
                      optt_pkg::S_SCAN : optt_pkg::S_EXEC;
        end
      end
      optt_pkg::S_EXEC:  state_nxt = optt_pkg::S_IDLE;
      optt_pkg::S_SCAN: begin
        if (scan_done) begin
          state_nxt = optt_pkg::S_FLUSH;
        end
      end
      optt_pkg::S_FLUSH: state_nxt = optt_pkg::S_IDLE;
      default:           state_nxt = optt_pkg::S_IDLE;
    endcase
  end

  // Output logic: handshake and the next result item.
  always_comb begin
    busy           = (state_r != optt_pkg::S_IDLE);
    accept         = start && !busy;
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = '0;
    out_status_nxt = optt_pkg::STS_IDLE_TICK;
    out_last_nxt   = 1'b1;
    unique case (state_r)
      optt_pkg::S_IDLE: begin
      end
      optt_pkg::S_EXEC: begin
        out_valid_nxt = 1'b1;
        if (cmd_op_r == optt_pkg::OP_CANCEL) begin
          out_slot_nxt   = cmd_idx_r;
          out_status_nxt = optt_pkg::STS_CANCELLED;
        end else if (free_found) begin
          out_slot_nxt   = OSW'(free_idx);
          out_status_nxt = optt_pkg::STS_STARTED;
        end else begin
          out_status_nxt = optt_pkg::STS_FULL;
        end
      end
      optt_pkg::S_SCAN: begin
        // A newer expiry proves the held one is not the final result.
        if (expired && pend_vld_r) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = OSW'(pend_idx_r);
          out_status_nxt = optt_pkg::STS_EXPIRED;
          out_last_nxt   = 1'b0;
        end
      end
      optt_pkg::S_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (pend_vld_r) begin
          out_slot_nxt   = OSW'(pend_idx_r);
          out_status_nxt = optt_pkg::STS_EXPIRED;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= optt_pkg::S_IDLE;
      time_r      <= '0;
      in_use_r    <= '0;
      cnt_r       <= '0;
      eval_vld_r  <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      eval_vld_r  <= (state_r == optt_pkg::S_SCAN) && !scan_done;

      if (accept && (optt_pkg::op_t'(in_operation) == optt_pkg::OP_TICK)) begin
        time_r <= time_r + TIME_BITS'(1);
        cnt_r  <= '0;
      end

      // Start claims the free slot; cancel frees an in-range slot.
      if (state_r == optt_pkg::S_EXEC) begin
        if (cmd_op_r == optt_pkg::OP_CANCEL) begin
          if (cancel_hit) begin
            in_use_r[SW'(cmd_idx_r)] <= 1'b0;
          end
        end else if (free_found) begin
          in_use_r[free_idx] <= 1'b1;
        end
      end

      // Scan walk: issue reads, evaluate one slot per cycle.
      if (state_r == optt_pkg::S_SCAN) begin
        if (!scan_done) begin
          cnt_r <= cnt_r + CW'(1);
        end
        if (expired) begin
          pend_vld_r <= 1'b1;
          if (!rd_repeats) begin
            in_use_r[eval_idx_r] <= 1'b0;
          end
        end
      end

      if (state_r == optt_pkg::S_FLUSH) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op_r    <= optt_pkg::op_t'(in_operation);
      cmd_delay_r <= in_delay_ticks;
      cmd_idx_r   <= in_slot_index;
    end
    eval_idx_r <= cnt_r[SW-1:0];
    if (expired) begin
      pend_idx_r <= eval_idx_r;
    end
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_slot   = out_slot_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

/* rtl/optt_checker.sv */
// ----------------------------------------------------------------------------
// optt_checker: port-level checks for the timer slot table
// Watches the handshake and result ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module optt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [3:0] out_slot,
  input logic [2:0] out_status,
  input logic       out_last
);

  // An accepted item always raises busy in the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy
  ) else $error("busy not raised after an accepted item");

  // Start and cancel give exactly one result, so it is the final one.
  a_single_result_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == optt_pkg::STS_STARTED ||
                   out_status == optt_pkg::STS_FULL ||
                   out_status == optt_pkg::STS_CANCELLED)) |-> out_last
  ) else $error("single-result item without last");

  // An idle tick reports slot zero as its only result.
  a_idle_tick: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == optt_pkg::STS_IDLE_TICK) |->
      (out_slot == 4'd0 && out_last)
  ) else $error("malformed idle tick result");

  // A full table reports slot zero.
  a_full_slot: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == optt_pkg::STS_FULL) |-> (out_slot == 4'd0)
  ) else $error("table full result with nonzero slot");

  // Results never follow a final result while the block is already idle.
  a_no_stray_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !busy && !start) |=> !out_valid
  ) else $error("result without an item in flight");

endmodule

bind oneshot_periodic_timer_table optt_checker u_optt_checker (.*);
